@@ sv/generational_handle_table_defines.svh @@
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GTH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("generational handle table: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GTH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("generational handle table: next-cycle check failed");

`endif

@@ sv/gth_pkg.sv @@
// ----------------------------------------------------------------------------
// Generational handle table package
// Field widths, request and status codes, and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gth_pkg;

	localparam int SLOT_W = 8;
	localparam int GEN_W  = 31;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [GEN_W-1:0]   gen;
	} result_t;

endpackage

@@ sv/gth_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data registered, held when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/gth_eval.sv @@
// ----------------------------------------------------------------------------
// Generational handle table request evaluator
// Validates a handle against its entry, bumps generations, forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gth_eval #(
	parameter int SLOTS = 256
) (
	input  logic [1:0]                   mode,
	input  logic [gth_pkg::SLOT_W-1:0]   slot,
	input  logic [gth_pkg::GEN_W-1:0]    gen,
	input  logic                         free_nz,
	input  logic [$clog2(SLOTS+1)-1:0]   used,
	input  logic [$clog2(SLOTS)-1:0]     pop_slot,
	input  logic                         mem_occ,
	input  logic [gth_pkg::GEN_W-1:0]    mem_gen,
	output gth_pkg::result_t             res,
	output logic                         commit
);

	import gth_pkg::*;

	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	logic             handle_ok;
	logic [GEN_W-1:0] bump;

	// A slot at or above the fill mark was never allocated: its entry is junk.
	assign handle_ok = (gen != '0) && (CMP_W'(slot) < CMP_W'(used)) && mem_occ &&
		(mem_gen == gen);

	// Wrap within the field and skip zero.
	always_comb begin
		bump = mem_gen + GEN_W'(1);
		if (bump == '0) begin
			bump = GEN_W'(1);
		end
	end

	always_comb begin
		res.status = ST_BAD;
		res.slot   = slot;
		res.gen    = gen;
		commit     = 1'b0;
		unique case (mode) inside
			MODE_ALLOC: begin
				if (free_nz) begin
					res.status = ST_OK;
					res.slot   = SLOT_W'(pop_slot);
					res.gen    = bump;
					commit     = 1'b1;
				end else if (used < CNT_W'(SLOTS)) begin
					res.status = ST_OK;
					res.slot   = SLOT_W'(used);
					res.gen    = GEN_W'(1);
					commit     = 1'b1;
				end else begin
					res.status = ST_FULL;
					res.slot   = '0;
					res.gen    = '0;
				end
			end
			MODE_FREE, MODE_LOOKUP: begin
				if (handle_ok) begin
					res.status = ST_OK;
					commit     = 1'b1;
				end
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase
	end

endmodule

@@ sv/generational_handle_table.sv @@
// ----------------------------------------------------------------------------
// Generational handle table
// Slot allocator with per-slot generation counters and a LIFO free stack.
// ----------------------------------------------------------------------------
// The block serves one request word at a time on the req channel and returns
// exactly one result word on the rsp channel. Allocate (mode 0) pops the most
// recently freed slot and bumps its generation (wrapping within 31 bits and
// skipping zero), or else hands out the next never-used slot at generation 1;
// with neither available it answers capacity exceeded with slot and
// generation zero. Free (mode 1) and lookup (mode 2) check the handle: the
// generation is nonzero, the slot lies below the fill mark, it is occupied
// and its stored generation matches. A good free clears occupancy and pushes
// the slot; any failed check, and mode 3, answers invalid and echoes the
// handle. Per-slot generation and occupancy share one 32-bit RAM word; the
// free stack is a second RAM. Both have a registered read. Slots at or above
// the fill mark are treated as never used, so no clearing pass runs after
// reset and the block takes a word right out of reset. A free or a lookup
// reads its slot's RAM word, then evaluates and writes back; an allocate of a
// fresh slot goes straight to evaluate; an allocate from the free stack first
// reads the stack RAM, then the popped slot's generation word, then evaluates.
// The next request stalls until evaluate finishes. The result sits in an
// output register, so a new request is taken while the previous result waits;
// a result that is still waiting holds the evaluate step until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_table_defines.svh"

module generational_handle_table #(
	parameter int SLOTS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 mode,
	input  logic [gth_pkg::SLOT_W-1:0] handle_slot,
	input  logic [gth_pkg::GEN_W-1:0]  handle_generation,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [1:0]                 status,
	output logic [gth_pkg::SLOT_W-1:0] out_slot,
	output logic [gth_pkg::GEN_W-1:0]  out_generation
);

	import gth_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t             state_q;
	logic [1:0]         mode_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [GEN_W-1:0]   gen_q;
	logic [CNT_W-1:0]   free_cnt_q;
	logic [CNT_W-1:0]   used_q;

	logic               rsp_valid_q;
	status_t            status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [GEN_W-1:0]   out_gen_q;

	logic               accept;
	logic               fin;
	logic               free_nz;
	logic               is_alloc_q;
	logic               is_free_q;
	logic               is_chk_in;

	// generation RAM: bit GEN_W is the occupied flag
	logic               gen_we;
	logic [IDX_W-1:0]   gen_waddr;
	logic [GEN_W:0]     gen_wdata;
	logic               gen_re;
	logic [IDX_W-1:0]   gen_raddr;
	logic [GEN_W:0]     gen_rdata;

	// free stack RAM
	logic               stk_we;
	logic               stk_re;
	logic [IDX_W-1:0]   stk_raddr;
	logic [IDX_W-1:0]   stk_rdata;

	result_t            res;
	logic               commit;
	logic               pop;
	logic               fresh;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign free_nz   = (free_cnt_q != '0);
	assign is_chk_in = (mode == MODE_FREE) || (mode == MODE_LOOKUP);
	assign is_alloc_q = (mode_q == MODE_ALLOC);
	assign is_free_q  = (mode_q == MODE_FREE);

	// Finish the evaluate step only when the output register can take the word.
	assign fin = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Stack top is read on accept; the popped slot then addresses the
	// generation RAM from S_POP. Free and lookup read their own slot at once.
	assign stk_re    = accept && (mode == MODE_ALLOC) && free_nz;
	assign stk_raddr = IDX_W'(free_cnt_q - CNT_W'(1));
	assign gen_re    = (accept && is_chk_in) || (state_q == S_POP);
	assign gen_raddr = (state_q == S_POP) ? stk_rdata : IDX_W'(handle_slot);

	gth_eval #(
		.SLOTS(SLOTS)
	) u_eval (
		.mode     (mode_q),
		.slot     (slot_q),
		.gen      (gen_q),
		.free_nz  (free_nz),
		.used     (used_q),
		.pop_slot (stk_rdata),
		.mem_occ  (gen_rdata[GEN_W]),
		.mem_gen  (gen_rdata[GEN_W-1:0]),
		.res      (res),
		.commit   (commit)
	);

	assign pop   = fin && commit && is_alloc_q && free_nz;
	assign fresh = fin && commit && is_alloc_q && !free_nz;

	// Write back: allocate marks occupied with the new generation, free keeps
	// the generation and drops occupancy.
	assign gen_we = fin && commit && (is_alloc_q || is_free_q);
	always_comb begin
		if (is_alloc_q) begin
			gen_waddr = free_nz ? stk_rdata : IDX_W'(used_q);
			gen_wdata = {1'b1, res.gen};
		end else begin
			gen_waddr = IDX_W'(slot_q);
			gen_wdata = {1'b0, gen_q};
		end
	end

	// Push a freed slot; drop it if the stack is already full.
	assign stk_we = fin && commit && is_free_q && (free_cnt_q < CNT_W'(SLOTS));

	gth_ram #(
		.WIDTH(GEN_W + 1),
		.DEPTH(SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gth_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SLOTS)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (IDX_W'(free_cnt_q)),
		.wdata (IDX_W'(slot_q)),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Sequencer: idle -> (pop) -> evaluate -> idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= stk_re ? S_POP : S_EXEC;
					end
				end
				S_POP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the request word for the evaluate step.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			slot_q <= handle_slot;
			gen_q  <= handle_generation;
		end
	end

	// Stack pointer and fill mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			used_q     <= '0;
		end else begin
			if (pop) begin
				free_cnt_q <= free_cnt_q - CNT_W'(1);
			end else if (stk_we) begin
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
			if (fresh) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	// Output register: load on finish, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q   <= res.status;
			out_slot_q <= res.slot;
			out_gen_q  <= res.gen;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign out_slot       = out_slot_q;
	assign out_generation = out_gen_q;

	// Every stacked slot was once handed out below the fill mark.
	`GTH_ASSERT_IMP(a_free_le_used, 1'b1, free_cnt_q <= used_q)
	// Capacity exceeded only with an empty stack and every slot used.
	`GTH_ASSERT_IMP(a_full_only_when_full, fin && (res.status == ST_FULL),
		(free_cnt_q == '0) && (used_q == CNT_W'(SLOTS)))
	// A good result never carries generation zero.
	`GTH_ASSERT_IMP(a_ok_gen_nonzero, rsp_valid_q && (status_q == ST_OK), out_gen_q != '0)
	// A pop lowers the stack pointer by exactly one.
	`GTH_ASSERT_NEXT(a_pop_decrements, pop, free_cnt_q == ($past(free_cnt_q) - CNT_W'(1)))

endmodule

@@ sim/generational_handle_table_tb.sv @@
// ----------------------------------------------------------------------------
// Generational handle table testbench
// Drives allocate, free, lookup and reserved request words into the table.
// Each accepted word runs through a local mirror of the slot generations,
// occupancy and free stack, and every result word is compared field by field
// with the mirror. A directed table comes first, then random traffic in three
// phases (fill to capacity, drain, mixed), with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_table_tb;
	import gth_pkg::*;

	localparam int SLOTS = 256;
	localparam logic [1:0] MODE_RSVD = 2'd3;
	localparam logic [GEN_W-1:0] GEN_MAX = 31'h7FFF_FFFF;
	localparam int N_RANDOM = 1230;
	localparam int FILL_END = 500;
	localparam int DRAIN_END = 880;
	localparam int PAUSE_AT = 640;
	localparam int LONG_HOLD = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_MAX = 10;

	typedef enum {
		PICK_ALLOC,
		PICK_FREE_LIVE,
		PICK_LOOKUP_LIVE,
		PICK_STALE,
		PICK_NOISE
	} pick_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		bit                typed;
		result_t           want;
	} dir_row_t;

	localparam result_t NO_WANT = '{ST_OK, 8'd0, 31'd0};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        mode = MODE_ALLOC;
	logic [SLOT_W-1:0] handle_slot = '0;
	logic [GEN_W-1:0]  handle_generation = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] out_slot;
	logic [GEN_W-1:0]  out_generation;

	// mirror of the table
	logic [GEN_W-1:0]  gen_mirror [SLOTS];
	bit                occ_mirror [SLOTS];
	logic [SLOT_W-1:0] free_lifo [SLOTS];
	int                free_depth = 0;
	int                fill_mark = 0;

	result_t awaited_rsp [$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      cycle_cnt = 0;

	// Directed words: typed-in results only where they are obvious, the
	// rest comes from the mirror.
	dir_row_t dir_rows [22] = '{
		'{MODE_LOOKUP, 8'd0,   31'd1,   1'b1, '{ST_BAD, 8'd0,   31'd1}},
		'{MODE_FREE,   8'd0,   31'd1,   1'b1, '{ST_BAD, 8'd0,   31'd1}},
		'{MODE_ALLOC,  8'd0,   31'd0,   1'b1, '{ST_OK,  8'd0,   31'd1}},
		'{MODE_ALLOC,  8'd255, GEN_MAX, 1'b1, '{ST_OK,  8'd1,   31'd1}},
		'{MODE_LOOKUP, 8'd0,   31'd1,   1'b0, NO_WANT},
		'{MODE_LOOKUP, 8'd0,   31'd0,   1'b1, '{ST_BAD, 8'd0,   31'd0}},
		'{MODE_LOOKUP, 8'd0,   31'd2,   1'b1, '{ST_BAD, 8'd0,   31'd2}},
		'{MODE_LOOKUP, 8'd1,   GEN_MAX, 1'b1, '{ST_BAD, 8'd1,   GEN_MAX}},
		'{MODE_LOOKUP, 8'd255, GEN_MAX, 1'b1, '{ST_BAD, 8'd255, GEN_MAX}},
		'{MODE_RSVD,   8'd0,   31'd1,   1'b1, '{ST_BAD, 8'd0,   31'd1}},
		'{MODE_RSVD,   8'd255, GEN_MAX, 1'b1, '{ST_BAD, 8'd255, GEN_MAX}},
		'{MODE_FREE,   8'd0,   31'd1,   1'b0, NO_WANT},
		'{MODE_LOOKUP, 8'd0,   31'd1,   1'b1, '{ST_BAD, 8'd0,   31'd1}},
		'{MODE_FREE,   8'd0,   31'd1,   1'b1, '{ST_BAD, 8'd0,   31'd1}},
		'{MODE_ALLOC,  8'd0,   31'd0,   1'b0, NO_WANT},
		'{MODE_FREE,   8'd1,   31'd1,   1'b0, NO_WANT},
		'{MODE_FREE,   8'd0,   31'd2,   1'b0, NO_WANT},
		'{MODE_ALLOC,  8'd0,   31'd0,   1'b0, NO_WANT},
		'{MODE_ALLOC,  8'd0,   31'd0,   1'b0, NO_WANT},
		'{MODE_ALLOC,  8'd0,   31'd0,   1'b0, NO_WANT},
		'{MODE_LOOKUP, 8'd2,   31'd1,   1'b0, NO_WANT},
		'{MODE_FREE,   8'd255, 31'd1,   1'b1, '{ST_BAD, 8'd255, 31'd1}}
	};

	generational_handle_table #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.handle_slot(handle_slot),
		.handle_generation(handle_generation),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.out_slot(out_slot),
		.out_generation(out_generation)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit handle_live(logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen);
		if (gen == '0 || slot >= fill_mark)
			return 1'b0;
		return occ_mirror[slot] && gen_mirror[slot] == gen;
	endfunction

	// Advance the mirror by one request word and return its result word.
	function automatic result_t handle_table_step(logic [1:0] op, logic [SLOT_W-1:0] slot,
			logic [GEN_W-1:0] gen);
		result_t r;
		logic [SLOT_W-1:0] s;
		logic [GEN_W-1:0] g;
		r.status = ST_BAD;
		r.slot = slot;
		r.gen = gen;
		case (op)
		MODE_ALLOC: begin
			if (free_depth > 0) begin
				// reuse the most recently freed slot, bump its generation
				free_depth--;
				s = free_lifo[free_depth];
				g = gen_mirror[s] + 1'b1;
				if (g == '0)
					g = GEN_W'(1);
				gen_mirror[s] = g;
				occ_mirror[s] = 1'b1;
				r = '{ST_OK, s, g};
			end else if (fill_mark < SLOTS) begin
				s = SLOT_W'(fill_mark);
				gen_mirror[s] = GEN_W'(1);
				occ_mirror[s] = 1'b1;
				fill_mark++;
				r = '{ST_OK, s, GEN_W'(1)};
			end else begin
				r = '{ST_FULL, '0, '0};
			end
		end
		MODE_FREE: begin
			if (handle_live(slot, gen)) begin
				occ_mirror[slot] = 1'b0;
				if (free_depth < SLOTS) begin
					free_lifo[free_depth] = slot;
					free_depth++;
				end
				r.status = ST_OK;
			end
		end
		MODE_LOOKUP: begin
			if (handle_live(slot, gen))
				r.status = ST_OK;
		end
		default: ;
		endcase
		return r;
	endfunction

	// Random used slot with the given occupancy, or -1 if there is none.
	function automatic int any_slot(bit want_occ);
		int hits [$];
		for (int i = 0; i < fill_mark; i++)
			if (occ_mirror[i] == want_occ)
				hits = {hits, i};
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	// Draw one random request word; the mix shifts from fill to drain to mixed.
	task automatic draw_word(input int idx, output logic [1:0] op,
			output logic [SLOT_W-1:0] slot, output logic [GEN_W-1:0] gen);
		int roll;
		int s;
		int cut [4];
		pick_t kind;
		roll = $urandom_range(0, 99);
		slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		gen = GEN_W'($urandom);
		if (idx < FILL_END)
			cut = '{70, 78, 88, 94};
		else if (idx < DRAIN_END)
			cut = '{15, 70, 82, 92};
		else
			cut = '{35, 65, 83, 92};
		if (roll < cut[0])
			kind = PICK_ALLOC;
		else if (roll < cut[1])
			kind = PICK_FREE_LIVE;
		else if (roll < cut[2])
			kind = PICK_LOOKUP_LIVE;
		else if (roll < cut[3])
			kind = PICK_STALE;
		else
			kind = PICK_NOISE;
		case (kind) inside
		PICK_ALLOC: op = MODE_ALLOC;
		PICK_FREE_LIVE, PICK_LOOKUP_LIVE: begin
			op = (kind == PICK_FREE_LIVE) ? MODE_FREE : MODE_LOOKUP;
			s = any_slot(1'b1);
			if (s >= 0) begin
				slot = SLOT_W'(s);
				gen = gen_mirror[s];
			end
		end
		PICK_STALE: begin
			op = $urandom_range(0, 1) ? MODE_FREE : MODE_LOOKUP;
			case ($urandom_range(0, 3))
			0: begin
				// live slot, wrong generation
				s = any_slot(1'b1);
				if (s >= 0) begin
					slot = SLOT_W'(s);
					gen = gen_mirror[s] + GEN_W'($urandom_range(1, 3));
				end
			end
			1: begin
				// live slot, zero generation
				s = any_slot(1'b1);
				if (s >= 0)
					slot = SLOT_W'(s);
				gen = '0;
			end
			2: begin
				// freed slot with its last generation
				s = any_slot(1'b0);
				if (s >= 0) begin
					slot = SLOT_W'(s);
					gen = gen_mirror[s];
				end
			end
			default: begin
				// slot never handed out
				if (fill_mark < SLOTS) begin
					slot = SLOT_W'($urandom_range(fill_mark, SLOTS - 1));
					gen = GEN_W'(1);
				end
			end
			endcase
		end
		default: op = 2'($urandom_range(0, 3));
		endcase
	endtask

	// Offer one request word after an optional gap; return once it is taken.
	task automatic offer_word(input logic [1:0] op, input logic [SLOT_W-1:0] slot,
			input logic [GEN_W-1:0] gen, input int gap, output result_t pred);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode <= op;
		handle_slot <= slot;
		handle_generation <= gen;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pred = handle_table_step(op, slot, gen);
	endtask

	// Result side: check each taken word, then stall at random.
	int rx_left = 0;
	int hold_left = 0;
	bit rx_calm = 1'b0;

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (awaited_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("unexpected result word: status %0d slot %0d gen %0d",
							status, out_slot, out_generation);
				end else begin
					want = awaited_rsp.pop_front();
					if (status !== want.status || out_slot !== want.slot ||
							out_generation !== want.gen) begin
						mismatches++;
						if (mismatches <= SHOW_MAX)
							$display("result mismatch: expected status %0d slot %0d gen %0d,",
								want.status, want.slot, want.gen,
								" got status %0d slot %0d gen %0d",
								status, out_slot, out_generation);
					end
				end
				if (results_seen % 150 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_left = rx_calm ? 0 : $urandom_range(0, 5);
				// long hold: let the block back up into its request side
				if (results_seen == 300 || results_seen == 900)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rx_left > 0) begin
				rx_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		result_t pred;
		logic [1:0] op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0] gen;
		bit tx_calm;
		tx_calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer_word(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].gen,
				$urandom_range(0, 5), pred);
			awaited_rsp = {awaited_rsp, (dir_rows[i].typed ? dir_rows[i].want : pred)};
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				tx_calm = ($urandom_range(0, 2) == 0);
			if (n == PAUSE_AT) begin
				// hold off until every result word has come back
				req_valid <= 1'b0;
				@(posedge clk);
				while (awaited_rsp.size() != 0)
					@(posedge clk);
			end
			draw_word(n, op, slot, gen);
			offer_word(op, slot, gen, tx_calm ? 0 : $urandom_range(0, 5), pred);
			awaited_rsp = {awaited_rsp, pred};
		end
		req_valid <= 1'b0;

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/gth_pkg.sv
sv/gth_ram.sv
sv/gth_eval.sv
sv/generational_handle_table.sv
sim/generational_handle_table_tb.sv
